### sv/bayer_same_phase_binning_assert.svh
// Assertion macros for the binning block's RTL files.
// Depends on nothing; included by the modules that carry assertions.
`ifndef BAYER_SAME_PHASE_BINNING_ASSERT_SVH
`define BAYER_SAME_PHASE_BINNING_ASSERT_SVH

// Same-cycle implication.
`define BSPB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BSPB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/bspb_pkg.sv
// Package for the Bayer same-phase binning block: widths, defaults, CSR map,
// controller state type and controller/datapath command and status structs.
// Depends on nothing.
package bspb_pkg;

   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int MAX_FACTOR_DEF = 16;

   localparam int PIX_W        = 8;
   localparam int SUM_W        = 14;
   localparam int ROW_W        = 12;
   localparam int HEIGHT_LIMIT = 4096;
   localparam int PHASES       = 4;
   localparam int DIM_W        = 13;
   localparam int SCALE_W      = 5;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;

   localparam logic [PIX_W-1:0]   PIX_MAX      = 8'd255;
   localparam logic [DIM_W-1:0]   WIDTH_RST    = 13'd1920;
   localparam logic [DIM_W-1:0]   HEIGHT_RST   = 13'd1080;
   localparam logic [SCALE_W-1:0] SCALE_RST    = 5'd2;

   typedef enum logic [1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_SCALE_FACTOR = 2'd2
   } csr_idx_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_ACC  = 2'd1,
      S_DIV  = 2'd2,
      S_OUT  = 2'd3
   } ctrl_state_type;

   typedef struct packed {
      logic take;       // pixel beat accepted: decode and advance counters
      logic store;      // update line store entry
      logic div_start;  // launch rounding divide
      logic load_rsp;   // move quotient to output register
   } ctrl_cmd_type;

   typedef struct packed {
      logic emit;       // current pixel closes a whole block
      logic div_busy;
      logic rsp_busy;   // output register full and not drained this cycle
   } dp_status_type;

endpackage

### sv/bspb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module bspb_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

### sv/bspb_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on nothing.
module bspb_div #(
   parameter int NUM_W = 15,
   parameter int DEN_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic [NUM_W-1:0] quo
);

   localparam int CNT_W = $clog2(NUM_W);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DEN_W:0]   trial;
   logic             ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      ge      = trial >= {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         cnt_in  = CNT_W'(NUM_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], ge};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;

endmodule

### sv/bspb_datapath.sv
// Datapath: raster counters, block decode, column-sum line store, divider
// and output register. Depends on bspb_pkg, bspb_ram and bspb_div.
module bspb_datapath #(
   parameter int MAX_WIDTH  = bspb_pkg::MAX_WIDTH_DEF,
   parameter int MAX_FACTOR = bspb_pkg::MAX_FACTOR_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bspb_pkg::ctrl_cmd_type               cmd,
   output bspb_pkg::dp_status_type              status,
   input  logic [$clog2(MAX_WIDTH):0]           cfg_width,
   input  logic [bspb_pkg::ROW_W:0]             cfg_height,
   input  logic [$clog2(MAX_FACTOR+1)-1:0]      cfg_scale,
   input  logic [bspb_pkg::PIX_W-1:0]           req_raw_pixel,
   input  logic                                 req_frame_start,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [bspb_pkg::PIX_W-1:0]           rsp_binned_pixel,
   output logic                                 rsp_row_end,
   output logic                                 rsp_frame_last
);

   import bspb_pkg::*;

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int WW    = CW + 1;
   localparam int AW    = $clog2(MAX_WIDTH / 2);
   localparam int FW    = $clog2(MAX_FACTOR + 1);
   localparam int BW    = (MAX_FACTOR > 2) ? $clog2(MAX_FACTOR) : 1;
   localparam int RW    = ROW_W;
   localparam int HW    = RW + 1;
   localparam int CPW   = CW + 1 + FW;
   localparam int RPW   = RW + 1 + FW;
   localparam int PH_SH = $clog2(PHASES);
   localparam int DVW   = 2 * FW - PH_SH;
   localparam int NUM_W = SUM_W + 1;

   // raster counters
   logic [CW-1:0] in_col_ff, in_col_in;
   logic [RW-1:0] in_row_ff, in_row_in;
   logic [CW-1:0] out_col_ff, out_col_in;
   logic [RW-1:0] out_row_ff, out_row_in;
   logic [BW-1:0] blk_x_ff, blk_x_in;
   logic [BW-1:0] blk_y_ff, blk_y_in;

   // counters after frame_start
   logic [CW-1:0] c_in_col, c_out_col;
   logic [RW-1:0] c_in_row, c_out_row;
   logic [BW-1:0] c_blk_x, c_blk_y;

   logic [CPW-1:0] col_prod;
   logic [RPW-1:0] row_prod;
   logic           col_in, row_in, col_last, row_last;
   logic           phase, blk_start, blk_end;
   logic [FW-1:0]  bx_inc, by_inc;
   logic [WW-1:0]  ic_inc;
   logic [HW-1:0]  ir_inc;

   // decoded pixel, held from take to the end of the item
   logic [AW-1:0]    addr_ff;
   logic [PIX_W-1:0] add_ff;
   logic             in_range_ff, blk_start_ff, blk_end_ff;
   logic             row_end_ff, frame_last_ff;

   logic [SUM_W-1:0]   ram_rdata, acc;
   logic [2*FW-1:0]    sq;
   logic [DVW-1:0]     den;
   logic [NUM_W-1:0]   num, quo;
   logic               div_busy;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]   binned_ff;
   logic               row_end_out_ff, frame_last_out_ff;

   always_comb begin
      c_in_col  = req_frame_start ? '0 : in_col_ff;
      c_in_row  = req_frame_start ? '0 : in_row_ff;
      c_out_col = req_frame_start ? '0 : out_col_ff;
      c_out_row = req_frame_start ? '0 : out_row_ff;
      c_blk_x   = req_frame_start ? '0 : blk_x_ff;
      c_blk_y   = req_frame_start ? '0 : blk_y_ff;

      // out_col < width / scale  <=>  (out_col + 1) * scale <= width
      col_prod = CPW'(({1'b0, c_out_col} + 1'b1) * cfg_scale);
      row_prod = RPW'(({1'b0, c_out_row} + 1'b1) * cfg_scale);
      col_in   = col_prod <= CPW'(cfg_width);
      row_in   = row_prod <= RPW'(cfg_height);
      col_last = (col_prod + CPW'(cfg_scale)) > CPW'(cfg_width);
      row_last = (row_prod + RPW'(cfg_scale)) > RPW'(cfg_height);

      bx_inc    = FW'(c_blk_x) + 1'b1;
      by_inc    = FW'(c_blk_y) + 1'b1;
      phase     = (c_blk_x[0] == c_out_col[0]) && (c_blk_y[0] == c_out_row[0]);
      blk_start = (c_blk_x == '0) && (c_blk_y == '0);
      blk_end   = (bx_inc == cfg_scale) && (by_inc == cfg_scale);

      // counter advance
      in_col_in  = c_in_col;
      in_row_in  = c_in_row;
      out_col_in = c_out_col;
      out_row_in = c_out_row;
      blk_x_in   = c_blk_x;
      blk_y_in   = c_blk_y;
      ic_inc     = WW'(c_in_col) + 1'b1;
      ir_inc     = HW'(c_in_row) + 1'b1;

      in_col_in = ic_inc[CW-1:0];
      if (bx_inc >= cfg_scale) begin
         blk_x_in   = '0;
         out_col_in = c_out_col + 1'b1;
      end else begin
         blk_x_in = BW'(bx_inc);
      end
      if (ic_inc >= cfg_width) begin
         in_col_in  = '0;
         blk_x_in   = '0;
         out_col_in = '0;
         in_row_in  = ir_inc[RW-1:0];
         if (by_inc >= cfg_scale) begin
            blk_y_in   = '0;
            out_row_in = c_out_row + 1'b1;
         end else begin
            blk_y_in = BW'(by_inc);
         end
         if (ir_inc >= cfg_height) begin
            in_row_in  = '0;
            blk_y_in   = '0;
            out_row_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         blk_x_ff   <= '0;
         blk_y_ff   <= '0;
      end else if (cmd.take) begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         blk_x_ff   <= blk_x_in;
         blk_y_ff   <= blk_y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         addr_ff       <= c_out_col[AW-1:0];
         add_ff        <= phase ? req_raw_pixel : '0;
         in_range_ff   <= col_in && row_in;
         blk_start_ff  <= blk_start;
         blk_end_ff    <= blk_end;
         row_end_ff    <= col_last;
         frame_last_ff <= col_last && row_last;
      end
   end

   // line store: read issued at take, written in the following cycle
   bspb_ram #(
      .WIDTH (SUM_W),
      .DEPTH (MAX_WIDTH / 2)
   ) u_sums (
      .clock (clock),
      .we    (cmd.store && in_range_ff),
      .waddr (addr_ff),
      .wdata (acc),
      .raddr (c_out_col[AW-1:0]),
      .rdata (ram_rdata)
   );

   always_comb begin
      acc = blk_start_ff ? SUM_W'(add_ff) : ram_rdata + SUM_W'(add_ff);
      sq  = (2 * FW)'(cfg_scale) * (2 * FW)'(cfg_scale);
      den = sq[2*FW-1:PH_SH];
      num = NUM_W'(acc) + NUM_W'(den >> 1);
   end

   bspb_div #(
      .NUM_W (NUM_W),
      .DEN_W (DVW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num),
      .den   (den),
      .busy  (div_busy),
      .quo   (quo)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.load_rsp) begin
         binned_ff         <= (quo > NUM_W'(PIX_MAX)) ? PIX_MAX : quo[PIX_W-1:0];
         row_end_out_ff    <= row_end_ff;
         frame_last_out_ff <= frame_last_ff;
      end
   end

   assign status.emit     = in_range_ff && blk_end_ff;
   assign status.div_busy = div_busy;
   assign status.rsp_busy = rsp_valid_ff && !rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_binned_pixel = binned_ff;
   assign rsp_row_end      = row_end_out_ff;
   assign rsp_frame_last   = frame_last_out_ff;

endmodule

### sv/bspb_ctrl.sv
// Controller state machine: sequences take, line-store update, divide and
// result load. Depends on bspb_pkg and the assertion macro header.
`include "bayer_same_phase_binning_assert.svh"

module bspb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  bspb_pkg::dp_status_type status,
   output bspb_pkg::ctrl_cmd_type  cmd
);

   import bspb_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            cmd.store = 1'b1;
            if (status.emit) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            if (!status.div_busy) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!status.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `BSPB_ASSERT_NEXT(a_div_launch, clock, reset, cmd.div_start, state_ff == S_DIV && status.div_busy, "divider not busy after launch")
   `BSPB_ASSERT_NOW(a_load_free, clock, reset, cmd.load_rsp, !status.rsp_busy, "result loaded over a pending beat")
   `BSPB_ASSERT_NEXT(a_take_acc, clock, reset, req_valid && req_ready, state_ff == S_ACC && !req_ready, "take not followed by accumulate")

endmodule

### sv/bayer_same_phase_binning.sv
// Bayer same-phase binning, top level: CSR block plus controller and datapath.
// Depends on bspb_pkg, bspb_ctrl and bspb_datapath.
//
// Reduces each scale_factor x scale_factor block of a raw Bayer raster to one
// pixel while keeping a valid Bayer mosaic: the output pixel's row/column
// parity picks which input phase inside the block is averaged. Pixels arrive
// in raster order on the req_ beat channel; frame_start on a beat clears all
// counters, and counters also wrap on their own after the last pixel of a
// frame. Columns and rows past the last whole block are consumed silently.
// Partial sums live in a per-output-column line store (one RAM of
// MAX_WIDTH/2 x 14 bits, written before it is read, no clearing pass). A
// finished sum is divided, rounding to nearest, by floor(scale^2/4) in a
// bit-serial divider and saturated at 255; row_end and frame_last tag the last
// pixel of an output row and of the frame. A pixel that closes no block is
// accepted, then its line-store entry is read, modified and written. A pixel
// that closes a block also waits for the 15-step divider and for any time the
// previous result is still unread. The result register lets the
// next pixel be taken while a result waits on rsp_. Registers (APB, 32-bit
// data): 0x0 frame_width (clamped 2..MAX_WIDTH), 0x4 frame_height (clamped
// 2..4096), 0x8 scale_factor (clamped 2..MAX_FACTOR); write only while idle.
module bayer_same_phase_binning #(
   parameter int MAX_WIDTH  = bspb_pkg::MAX_WIDTH_DEF,
   parameter int MAX_FACTOR = bspb_pkg::MAX_FACTOR_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // pixel input
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bspb_pkg::PIX_W-1:0]          req_raw_pixel,
   input  logic                                req_frame_start,
   // binned output
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bspb_pkg::PIX_W-1:0]          rsp_binned_pixel,
   output logic                                rsp_row_end,
   output logic                                rsp_frame_last,
   // register port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bspb_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [bspb_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [bspb_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   import bspb_pkg::*;

   localparam int WW = $clog2(MAX_WIDTH) + 1;
   localparam int HW = ROW_W + 1;
   localparam int FW = $clog2(MAX_FACTOR + 1);
   localparam int XW = DIM_W + 1;      // room for an 8192 clamp limit
   localparam int SW = SCALE_W + 1;    // room for a scale limit of 32

   logic [DIM_W-1:0]   width_ff, width_in;
   logic [DIM_W-1:0]   height_ff, height_in;
   logic [SCALE_W-1:0] scale_ff, scale_in;
   csr_idx_type        csr_idx;
   logic               csr_write;

   logic [XW-1:0]  w_ext, w_clamp;
   logic [XW-1:0]  h_ext, h_clamp;
   logic [SW-1:0]  f_ext, f_clamp;

   ctrl_cmd_type   cmd;
   dp_status_type  status;

   // register writes land on the access phase
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_idx   = csr_idx_type'(paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      scale_in  = scale_ff;
      prdata    = '0;
      unique case (csr_idx)
         CSR_FRAME_WIDTH: begin
            prdata = CSR_DATA_W'(width_ff);
            if (csr_write) begin
               width_in = pwdata[DIM_W-1:0];
            end
         end
         CSR_FRAME_HEIGHT: begin
            prdata = CSR_DATA_W'(height_ff);
            if (csr_write) begin
               height_in = pwdata[DIM_W-1:0];
            end
         end
         CSR_SCALE_FACTOR: begin
            prdata = CSR_DATA_W'(scale_ff);
            if (csr_write) begin
               scale_in = pwdata[SCALE_W-1:0];
            end
         end
         default: begin
            prdata = '0;   // unmapped offset: reads zero, writes dropped
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         scale_ff  <= SCALE_RST;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         scale_ff  <= scale_in;
      end
   end

   // out-of-range settings act as the nearest legal value
   always_comb begin
      w_ext = XW'(width_ff);
      h_ext = XW'(height_ff);
      f_ext = SW'(scale_ff);

      if (w_ext < XW'(2)) begin
         w_clamp = XW'(2);
      end else if (w_ext > XW'(MAX_WIDTH)) begin
         w_clamp = XW'(MAX_WIDTH);
      end else begin
         w_clamp = w_ext;
      end

      if (h_ext < XW'(2)) begin
         h_clamp = XW'(2);
      end else if (h_ext > XW'(HEIGHT_LIMIT)) begin
         h_clamp = XW'(HEIGHT_LIMIT);
      end else begin
         h_clamp = h_ext;
      end

      if (f_ext < SW'(2)) begin
         f_clamp = SW'(2);
      end else if (f_ext > SW'(MAX_FACTOR)) begin
         f_clamp = SW'(MAX_FACTOR);
      end else begin
         f_clamp = f_ext;
      end
   end

   bspb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bspb_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_FACTOR (MAX_FACTOR)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .cfg_width        (w_clamp[WW-1:0]),
      .cfg_height       (h_clamp[HW-1:0]),
      .cfg_scale        (f_clamp[FW-1:0]),
      .req_raw_pixel    (req_raw_pixel),
      .req_frame_start  (req_frame_start),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_binned_pixel (rsp_binned_pixel),
      .rsp_row_end      (rsp_row_end),
      .rsp_frame_last   (rsp_frame_last)
   );

endmodule
